/* rtl/ktcs_pkg.sv */
// shared types, codes and helpers for the keyed table with compaction
`default_nettype none

package ktcs_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BYTES    = 29;
    localparam int KEY_W        = 8 * KEY_BYTES;
    localparam int TAG_W        = 152;
    localparam int AMT_W        = 32;
    localparam int POS_W        = 4;
    localparam int FILL_W       = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [63:0]       key_bytes_0_7;
        logic [63:0]       key_bytes_8_15;
        logic [63:0]       key_bytes_16_23;
        logic [39:0]       key_bytes_24_28;
        logic [63:0]       tag_bytes_0_7;
        logic [63:0]       tag_bytes_8_15;
        logic [23:0]       tag_bytes_16_18;
        logic signed [31:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [POS_W-1:0]   position;
        logic [FILL_W-1:0]  fill_level;
        logic [63:0]        out_key_0_7;
        logic [63:0]        out_key_8_15;
        logic [63:0]        out_key_16_23;
        logic [39:0]        out_key_24_28;
        logic [63:0]        out_tag_0_7;
        logic [63:0]        out_tag_8_15;
        logic [23:0]        out_tag_16_18;
        logic signed [31:0] out_amount;
        logic               last;
    } t_out_item;

    // one table entry, key byte 0 in the low bits
    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [TAG_W-1:0]       tag;
        logic signed [AMT_W-1:0] amount;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    localparam t_entry ENTRY_ZERO = '0;

    function automatic t_entry item_entry(input t_in_item it);
        t_entry e;
        e.key    = {it.key_bytes_24_28, it.key_bytes_16_23, it.key_bytes_8_15,
                    it.key_bytes_0_7};
        e.tag    = {it.tag_bytes_16_18, it.tag_bytes_8_15, it.tag_bytes_0_7};
        e.amount = it.amount;
        return e;
    endfunction

    function automatic t_out_item make_out(input t_status st,
                                           input logic [POS_W-1:0] pos,
                                           input logic [FILL_W-1:0] fill,
                                           input t_entry e,
                                           input logic lst);
        t_out_item r;
        r.status        = st;
        r.position      = pos;
        r.fill_level    = fill;
        r.out_key_0_7   = e.key[63:0];
        r.out_key_8_15  = e.key[127:64];
        r.out_key_16_23 = e.key[191:128];
        r.out_key_24_28 = e.key[231:192];
        r.out_tag_0_7   = e.tag[63:0];
        r.out_tag_8_15  = e.tag[127:64];
        r.out_tag_16_18 = e.tag[151:128];
        r.out_amount    = e.amount;
        r.last          = lst;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ktcs_cell.sv */
// one table slot: holds an entry, loads or takes its neighbor's entry, compares its key
`default_nettype none

module ktcs_cell (
    input  wire logic                     i_clk,
    input  wire ktcs_pkg::t_cell_ctl      i_ctl,
    input  wire ktcs_pkg::t_entry         i_new,
    input  wire ktcs_pkg::t_entry         i_next,
    input  wire logic [ktcs_pkg::KEY_W-1:0] i_probe,
    output ktcs_pkg::t_entry              o_entry,
    output logic                          o_match
);

    ktcs_pkg::t_entry r_entry;
    logic             r_match;
    logic             n_match;

    // string compare: bytes up to and including the first zero byte must agree
    always_comb begin
        logic ended;
        ended   = 1'b0;
        n_match = 1'b1;
        for (int b = 0; b < ktcs_pkg::KEY_BYTES; b++) begin
            if (!ended) begin
                if (r_entry.key[8*b +: 8] != i_probe[8*b +: 8]) begin
                    n_match = 1'b0;
                end
                if (r_entry.key[8*b +: 8] == 8'd0) begin
                    ended = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

`default_nettype wire

/* rtl/keyed_table_compacting_store.sv */
// insert, search, remove-with-compaction and list over a chain of entry cells
// insert, full and empty results are registered from the exec state after the transaction is taken
// search and remove test one cell per cycle while the output is free: result registered on a hit or at the last cell
// list: results registered from the list state, one per cycle while the output is free, count results
// the next transaction can be taken the cycle after the last result; o_in_stall is high until then, so
// one transaction is in flight at a time; an output stall holds the sequencer
// reset clears the fill count and control; entry contents stay undefined until written
`default_nettype none

module keyed_table_compacting_store #(
    parameter int CAPACITY = ktcs_pkg::CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ktcs_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ktcs_pkg::t_out_item      o_out_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_LIST
    } t_state;

    t_state              r_state;
    ktcs_pkg::t_in_item  r_item;
    ktcs_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_idx;

    ktcs_pkg::t_entry    w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    ktcs_pkg::t_cell_ctl w_ctl   [CAPACITY];
    ktcs_pkg::t_entry    w_new;
    ktcs_pkg::t_entry    w_rd;
    logic                w_hit;
    logic                w_out_free;
    logic                w_full;
    logic                w_scan_end;
    logic                w_do_insert;
    logic                w_do_remove;
    logic                w_emit;

    assign w_new = ktcs_pkg::item_entry(r_item);

    always_comb begin
        w_out_free  = !r_out_valid || !i_out_stall;
        w_full      = (r_count == CW'(CAPACITY));
        w_rd        = w_entry[r_idx];
        w_hit       = w_match[r_idx];
        w_scan_end  = ((CW'(r_idx) + CW'(1)) == r_count);
        w_do_insert = (r_state == S_EXEC) && (r_item.opcode == ktcs_pkg::OP_INSERT)
                      && !w_full && w_out_free;
        w_do_remove = (r_state == S_SCAN) && (r_item.opcode == ktcs_pkg::OP_REMOVE)
                      && w_hit && w_out_free;
        // a result is registered this cycle
        case (r_state)
            S_EXEC: begin
                w_emit = w_out_free && ((r_item.opcode == ktcs_pkg::OP_INSERT)
                                        || (r_count == '0));
            end
            S_SCAN: begin
                w_emit = w_out_free && (w_hit || w_scan_end);
            end
            S_LIST: begin
                w_emit = w_out_free;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        ktcs_pkg::t_entry w_next;

        if (j + 1 < CAPACITY) begin : g_mid
            assign w_next = w_entry[j+1];
        end else begin : g_end
            assign w_next = w_entry[j];
        end

        // cells at and above the removed slot take their upper neighbor
        always_comb begin
            w_ctl[j].load  = w_do_insert && (r_count == CW'(j));
            w_ctl[j].shift = w_do_remove && (CW'(j) >= CW'(r_idx));
        end

        ktcs_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[j]),
            .i_new   (w_new),
            .i_next  (w_next),
            .i_probe (w_new.key),
            .o_entry (w_entry[j]),
            .o_match (w_match[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_idx <= '0;
                        if (r_item.opcode == ktcs_pkg::OP_INSERT) begin
                            r_state     <= S_IDLE;
                            if (w_full) begin
                                r_out <= ktcs_pkg::make_out(ktcs_pkg::ST_FULL, '0,
                                    ktcs_pkg::FILL_W'(r_count), ktcs_pkg::ENTRY_ZERO, 1'b1);
                            end else begin
                                r_out <= ktcs_pkg::make_out(ktcs_pkg::ST_OK,
                                    ktcs_pkg::POS_W'(r_count),
                                    ktcs_pkg::FILL_W'(r_count + CW'(1)), w_new, 1'b1);
                                r_count <= r_count + CW'(1);
                            end
                        end else if (r_count == '0) begin
                            r_state     <= S_IDLE;
                            r_out <= ktcs_pkg::make_out(ktcs_pkg::ST_EMPTY, '0, '0,
                                ktcs_pkg::ENTRY_ZERO, 1'b1);
                        end else if (r_item.opcode == ktcs_pkg::OP_LIST) begin
                            r_state <= S_LIST;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_out_free) begin
                        if (w_hit) begin
                            r_state     <= S_IDLE;
                            if (r_item.opcode == ktcs_pkg::OP_REMOVE) begin
                                r_out <= ktcs_pkg::make_out(ktcs_pkg::ST_OK,
                                    ktcs_pkg::POS_W'(r_idx),
                                    ktcs_pkg::FILL_W'(r_count - CW'(1)), w_rd, 1'b1);
                                r_count <= r_count - CW'(1);
                            end else begin
                                r_out <= ktcs_pkg::make_out(ktcs_pkg::ST_OK,
                                    ktcs_pkg::POS_W'(r_idx),
                                    ktcs_pkg::FILL_W'(r_count), w_rd, 1'b1);
                            end
                        end else if (w_scan_end) begin
                            r_state     <= S_IDLE;
                            r_out <= ktcs_pkg::make_out(ktcs_pkg::ST_MISS, '0,
                                ktcs_pkg::FILL_W'(r_count), ktcs_pkg::ENTRY_ZERO, 1'b1);
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_LIST: begin
                    if (w_out_free) begin
                        r_out <= ktcs_pkg::make_out(ktcs_pkg::ST_OK,
                            ktcs_pkg::POS_W'(r_idx), ktcs_pkg::FILL_W'(r_count),
                            w_rd, w_scan_end);
                        if (w_scan_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted transaction did not start execution");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ktcs_pkg::ST_OK)) |-> o_out_data.last)
        else $error("error status without last mark");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_remove |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the table");
`endif

endmodule

`default_nettype wire
